// File: hw/rtl/hwg_pkg.sv
// Shared types, register codes and the sine table function of the harmonic wavetable generator.
`timescale 1ns / 1ps

package hwg_pkg;

    // Port and field widths fixed by the register map.
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 10;
    localparam int COUNT_W        = 3;
    localparam int LEN_W          = 4;
    localparam int WEIGHT_W       = 10;
    localparam int SAMPLE_INDEX_W = 12;
    localparam int SAMPLE_W       = 8;
    localparam int NUM_WEIGHTS    = 6;

    // Datapath widths: Q15 sine with sign, Q8 weight, sum of up to six products.
    localparam int SINE_W = 16;
    localparam int PROD_W = WEIGHT_W + SINE_W;
    localparam int ACC_W  = PROD_W + 3;

    // Shortest allowed table, as log2 of its length.
    localparam int MIN_LEN_LOG2 = 4;

    // Output scaling: sample = floor(127 * acc / 2^23) + 128.
    localparam int AMPLITUDE  = 127;
    localparam int MIDSCALE   = 128;
    localparam int FRAC_BITS  = 23;
    localparam int SAMPLE_MAX = 255;

    // Polynomial coefficients of the quarter-wave sine, all Q15.
    localparam logic [31:0] SIN_A   = 32'd51472;
    localparam logic [31:0] SIN_B   = 32'd21024;
    localparam logic [31:0] SIN_C   = 32'd2320;
    localparam logic [31:0] SIN_CAP = 32'd32767;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH_LOG2 = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FIRST      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SECOND     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_THIRD      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FOURTH     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FIFTH      = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SIXTH      = 4'd7;

    // Settings that one harmonic cell needs from the register file.
    typedef struct packed {
        logic                       enable;
        logic [LEN_W-1:0]           len_log2;
        logic signed [WEIGHT_W-1:0] weight;
    } cell_ctrl_t;

    // Quarter-wave sine magnitude at distance d from the zero crossing, used only
    // with constant arguments to build the table.
    function automatic logic [14:0] quarter_sine(input int unsigned d, input int unsigned qlog);
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] s;
        x  = 32'(d) << (15 - qlog);
        x2 = (x * x) >> 15;
        t1 = SIN_B - ((x2 * SIN_C) >> 15);
        t2 = SIN_A - ((x2 * t1) >> 15);
        s  = (x * t2) >> 15;
        if (s > SIN_CAP) begin
            s = SIN_CAP;
        end
        return s[14:0];
    endfunction

endpackage

// File: hw/rtl/harmonic_wavetable_generator.sv
// Top level of the harmonic wavetable generator: registers, cell chain and output stage.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the s_ channel carries one sample index; the block returns one
// 8-bit sample on the m_ channel, with m_clipped set when the sum had to be limited
// to 0 or 255. Results leave in the order the indexes arrived.
// The cfg_ channel writes one register per transfer (index 0 harmonic count,
// 1 table length log2, 2..7 the six weights); cfg_ready is always high and writes
// to indexes past the list are dropped. Write registers only while the block is idle.
// Each sample passes one cell of four stages per harmonic (phase and table address,
// sine table read, weight multiply, accumulate), then a saturation register; the
// first stage loads on the transfer edge itself.
// Throughput is one sample per cycle while the receiver does not stall; every stage holds a different sample.
// When the receiver stalls, each stage still fills any empty slot ahead of it, so
// inputs keep being taken until the whole chain is full; nothing is dropped.
// Reset clears all stage valids and loads the register defaults (one harmonic at
// full weight, table length 256). There is no clearing pass.
module harmonic_wavetable_generator #(
    parameter int MAX_HARMONICS    = 6,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_LENGTH_LOG2  = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hwg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [hwg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [hwg_pkg::SAMPLE_INDEX_W-1:0]    s_sample_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hwg_pkg::SAMPLE_W-1:0]          m_sample_value,
    output logic                                  m_clipped
);
    import hwg_pkg::*;

    localparam int PH_W = MAX_LENGTH_LOG2;

    // Configuration registers.
    logic [COUNT_W-1:0]         count_reg;
    logic [LEN_W-1:0]           len_log2_reg;
    logic signed [WEIGHT_W-1:0] weight_reg [NUM_WEIGHTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= COUNT_W'(1);
            len_log2_reg  <= LEN_W'(8);
            weight_reg[0] <= WEIGHT_W'(256);
            weight_reg[1] <= '0;
            weight_reg[2] <= '0;
            weight_reg[3] <= '0;
            weight_reg[4] <= '0;
            weight_reg[5] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HARMONIC_COUNT:    count_reg     <= cfg_data[COUNT_W-1:0];
                REG_TABLE_LENGTH_LOG2: len_log2_reg  <= cfg_data[LEN_W-1:0];
                REG_WEIGHT_FIRST:      weight_reg[0] <= cfg_data;
                REG_WEIGHT_SECOND:     weight_reg[1] <= cfg_data;
                REG_WEIGHT_THIRD:      weight_reg[2] <= cfg_data;
                REG_WEIGHT_FOURTH:     weight_reg[3] <= cfg_data;
                REG_WEIGHT_FIFTH:      weight_reg[4] <= cfg_data;
                REG_WEIGHT_SIXTH:      weight_reg[5] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the count and the table length to their supported ranges.
    logic [COUNT_W-1:0] count_eff;
    logic [LEN_W-1:0]   len_log2_eff;

    always_comb begin
        count_eff = count_reg;
        if (32'(count_reg) > MAX_HARMONICS) begin
            count_eff = COUNT_W'(MAX_HARMONICS);
        end
        len_log2_eff = len_log2_reg;
        if (32'(len_log2_reg) < MIN_LEN_LOG2) begin
            len_log2_eff = LEN_W'(MIN_LEN_LOG2);
        end else if (32'(len_log2_reg) > MAX_LENGTH_LOG2) begin
            len_log2_eff = LEN_W'(MAX_LENGTH_LOG2);
        end
    end

    // Links of the cell chain; link 0 is the input, the last link feeds the output stage.
    logic                    chain_valid [MAX_HARMONICS+1];
    logic                    chain_ready [MAX_HARMONICS+1];
    logic [PH_W-1:0]         chain_idx   [MAX_HARMONICS+1];
    logic [PH_W-1:0]         chain_phase [MAX_HARMONICS+1];
    logic signed [ACC_W-1:0] chain_acc   [MAX_HARMONICS+1];

    // The index wraps modulo the table length before it enters the chain.
    logic [PH_W-1:0] len_mask;

    assign len_mask       = ~({PH_W{1'b1}} << len_log2_eff);
    assign chain_valid[0] = s_valid;
    assign chain_idx[0]   = PH_W'(s_sample_index) & len_mask;
    assign chain_phase[0] = '0;
    assign chain_acc[0]   = '0;
    assign s_ready        = chain_ready[0];

    // One cell per harmonic.
    for (genvar i = 0; i < MAX_HARMONICS; i++) begin : g_cell
        cell_ctrl_t ctrl;

        assign ctrl.enable   = (count_eff > COUNT_W'(i));
        assign ctrl.len_log2 = len_log2_eff;
        assign ctrl.weight   = weight_reg[i];

        hwg_cell #(
            .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
            .MAX_LENGTH_LOG2  (MAX_LENGTH_LOG2)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_idx    (chain_idx[i]),
            .in_phase  (chain_phase[i]),
            .in_acc    (chain_acc[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_idx   (chain_idx[i+1]),
            .out_phase (chain_phase[i+1]),
            .out_acc   (chain_acc[i+1])
        );
    end

    // Scale by 127, offset by 128 and saturate to the byte range.
    localparam int T_W = ACC_W + 8;

    logic signed [T_W-1:0] scaled;
    logic signed [T_W-1:0] total;
    logic [T_W-FRAC_BITS-1:0] whole;
    logic [SAMPLE_W-1:0]   sample_next;
    logic                  clipped_next;

    assign scaled = (T_W'(chain_acc[MAX_HARMONICS]) <<< 7) - T_W'(chain_acc[MAX_HARMONICS]);
    assign total  = scaled + (T_W'(MIDSCALE) <<< FRAC_BITS);
    assign whole  = total[T_W-1:FRAC_BITS];

    always_comb begin
        sample_next  = whole[SAMPLE_W-1:0];
        clipped_next = 1'b0;
        if (total < 0) begin
            sample_next  = '0;
            clipped_next = 1'b1;
        end else if (whole > (T_W-FRAC_BITS)'(SAMPLE_MAX)) begin
            sample_next  = SAMPLE_W'(SAMPLE_MAX);
            clipped_next = 1'b1;
        end
    end

    // Output register; it takes a new result whenever it is empty or being drained.
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_value_reg;
    logic                m_clipped_reg;
    logic                out_en;

    assign out_en                     = !m_valid_reg || m_ready;
    assign chain_ready[MAX_HARMONICS] = out_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= chain_valid[MAX_HARMONICS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_sample_value_reg <= sample_next;
            m_clipped_reg      <= clipped_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_value_reg;
    assign m_clipped      = m_clipped_reg;

endmodule

// File: hw/rtl/hwg_cell.sv
// One harmonic cell: steps the phase, reads the sine and adds its weighted term.
`timescale 1ns / 1ps

module hwg_cell #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_LENGTH_LOG2  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hwg_pkg::cell_ctrl_t                 ctrl,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [MAX_LENGTH_LOG2-1:0]          in_idx,
    input  logic [MAX_LENGTH_LOG2-1:0]          in_phase,
    input  logic signed [hwg_pkg::ACC_W-1:0]    in_acc,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [MAX_LENGTH_LOG2-1:0]          out_idx,
    output logic [MAX_LENGTH_LOG2-1:0]          out_phase,
    output logic signed [hwg_pkg::ACC_W-1:0]    out_acc
);
    import hwg_pkg::*;

    localparam int PH_W    = MAX_LENGTH_LOG2;
    localparam int DLOG    = $clog2(SINE_TABLE_DEPTH);
    localparam int QLOG    = DLOG - 2;
    localparam int QUARTER = 1 << QLOG;

    // Quarter-wave table, one entry more than a quarter so the peak is included.
    logic [14:0] quarter_rom [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        assign quarter_rom[k] = quarter_sine(k, QLOG);
    end

    // Stage valids and per-stage load enables; a stage loads when empty or draining.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Stage registers.
    logic [PH_W-1:0]          s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [PH_W-1:0]          s1_phase_reg, s2_phase_reg, s3_phase_reg, s4_phase_reg;
    logic signed [ACC_W-1:0]  s1_acc_reg, s2_acc_reg, s3_acc_reg, s4_acc_reg;
    logic [DLOG-1:0]          s1_addr_reg;
    logic [14:0]              s2_rom_reg;
    logic                     s2_neg_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;

    // Phase of this harmonic is the previous harmonic's phase plus the index.
    logic [PH_W-1:0]      len_mask;
    logic [PH_W-1:0]      s1_phase_next;
    logic [PH_W+DLOG-1:0] addr_wide;
    logic [DLOG-1:0]      s1_addr_next;

    assign len_mask      = ~({PH_W{1'b1}} << ctrl.len_log2);
    assign s1_phase_next = (in_phase + in_idx) & len_mask;
    assign addr_wide     = {s1_phase_next, {DLOG{1'b0}}} >> ctrl.len_log2;
    assign s1_addr_next  = addr_wide[DLOG-1:0];

    // Fold the table address into a quarter-wave distance and a sign.
    logic [1:0]      quadrant;
    logic [QLOG:0]   quarter_dist;

    assign quadrant     = s1_addr_reg[DLOG-1 -: 2];
    assign quarter_dist = quadrant[0] ? ((QLOG+1)'(QUARTER) - {1'b0, s1_addr_reg[QLOG-1:0]})
                                      : {1'b0, s1_addr_reg[QLOG-1:0]};

    // Signed sine and the weighted term.
    logic signed [SINE_W-1:0] sine_val;
    logic signed [PROD_W-1:0] s3_prod_next;
    logic signed [ACC_W-1:0]  s4_acc_next;

    assign sine_val     = s2_neg_reg ? -$signed({1'b0, s2_rom_reg}) : $signed({1'b0, s2_rom_reg});
    assign s3_prod_next = ctrl.weight * sine_val;
    assign s4_acc_next  = s3_acc_reg + (ctrl.enable ? ACC_W'(s3_prod_reg) : '0);

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload, including the registered table read.
    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_idx_reg   <= in_idx;
            s1_phase_reg <= s1_phase_next;
            s1_acc_reg   <= in_acc;
            s1_addr_reg  <= s1_addr_next;
        end
        if (en2) begin
            s2_idx_reg   <= s1_idx_reg;
            s2_phase_reg <= s1_phase_reg;
            s2_acc_reg   <= s1_acc_reg;
            s2_rom_reg   <= quarter_rom[quarter_dist];
            s2_neg_reg   <= quadrant[1];
        end
        if (en3) begin
            s3_idx_reg   <= s2_idx_reg;
            s3_phase_reg <= s2_phase_reg;
            s3_acc_reg   <= s2_acc_reg;
            s3_prod_reg  <= s3_prod_next;
        end
        if (en4) begin
            s4_idx_reg   <= s3_idx_reg;
            s4_phase_reg <= s3_phase_reg;
            s4_acc_reg   <= s4_acc_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_idx   = s4_idx_reg;
    assign out_phase = s4_phase_reg;
    assign out_acc   = s4_acc_reg;

endmodule

// File: hw/rtl/hwg_checker.sv
// Port-level assertions for the harmonic wavetable generator, bound to the top level.
`timescale 1ns / 1ps

module hwg_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [hwg_pkg::SAMPLE_W-1:0]       m_sample_value,
    input logic                               m_clipped
);
    import hwg_pkg::*;

    // Reset empties the pipeline, so no result is offered right after it.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_value) && $stable(m_clipped))
        else $error("stalled result changed");

    // Input is refused only when the chain is full and the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused while a slot was free");

    // A clipped sample sits at one of the rails.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> m_sample_value == '0 || m_sample_value == SAMPLE_W'(SAMPLE_MAX))
        else $error("clipped sample not at a rail");

endmodule

bind harmonic_wavetable_generator hwg_checker u_hwg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sample_value (m_sample_value),
    .m_clipped      (m_clipped)
);
